FILE: design/stq_pkg.sv
`default_nettype none
package stq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_EXPIRE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_OWNER = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  owner_id;
    logic [31:0] time_req;
    logic [31:0] payload;
    logic        has_callback;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  fired_owner;
    logic [31:0] fired_time;
    logic [31:0] fired_payload;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  owner;
    logic [31:0] payload;
    logic        notify;
    logic [31:0] stamp;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       step;
    logic       insert;
    logic       remove_best;
    logic       pop_head;
    logic       clear;
    logic       emit_done;
    logic [1:0] status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       owner_zero;
    logic       full;
    logic       scan_end;
    logic       ins_stop;
    logic       found;
    logic       head_lt;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/sorted_timer_queue_core.sv
// add scans past entries at or before the new deadline, then inserts; expire pops
// head entries due before the request time; clear empties the table; delete
// removes the owner's oldest entry per pass; the slot scan walks one entry a cycle
// throughput: one request in flight; start is taken while busy is low
// reset: synchronous, empties the table, clears the stamp counter and controller;
// the receiver cannot stall, each result shows for one cycle with rsp_valid
`default_nettype none
module sorted_timer_queue_core #(
  parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire stq_pkg::req_t req,
  output stq_pkg::rsp_t      rsp,
  output logic               rsp_valid
);

  stq_pkg::dp_cmd_t  dc;
  stq_pkg::dp_stat_t st;

  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .dc    (dc)
  );

  stq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .dc        (dc),
    .st        (st),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
  );

endmodule
`default_nettype wire

FILE: design/stq_ctrl.sv
`default_nettype none
module stq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire stq_pkg::dp_stat_t st,
  output stq_pkg::dp_cmd_t      dc
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_EXP  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] status, status_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= stq_pkg::STATUS_OK;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

  always_comb begin
    state_next = state;
    status_next = status;
    dc = '0;
    dc.status = status;
    case (state)
      S_IDLE: begin
        if (start) begin
          dc.latch = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        status_next = stq_pkg::STATUS_OK;
        case (st.cmd)
          stq_pkg::CMD_ADD: begin
            if (st.owner_zero) begin
              status_next = stq_pkg::STATUS_NO_OWNER;
              state_next = S_DONE;
            end else if (st.full) begin
              status_next = stq_pkg::STATUS_FULL;
              state_next = S_DONE;
            end else begin
              state_next = S_INS;
            end
          end
          stq_pkg::CMD_DELETE: begin
            if (st.owner_zero) begin
              status_next = stq_pkg::STATUS_NO_OWNER;
              state_next = S_DONE;
            end else begin
              state_next = S_DEL;
            end
          end
          stq_pkg::CMD_EXPIRE: state_next = S_EXP;
          default: begin
            dc.clear = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      S_INS: begin
        if (st.scan_end || st.ins_stop) begin
          dc.insert = 1'b1;
          state_next = S_DONE;
        end else begin
          dc.step = 1'b1;
        end
      end
      S_DEL: begin
        // full pass done: remove the oldest match and rescan
        if (st.scan_end) begin
          if (st.found) begin
            dc.remove_best = 1'b1;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          dc.step = 1'b1;
        end
      end
      S_EXP: begin
        if (st.head_lt) begin
          dc.pop_head = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        dc.emit_done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/stq_datapath.sv
`default_nettype none
module stq_datapath #(
  parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire stq_pkg::req_t     req,
  input  wire stq_pkg::dp_cmd_t  dc,
  output stq_pkg::dp_stat_t      st,
  output stq_pkg::rsp_t          rsp,
  output logic                   rsp_valid
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  stq_pkg::slot_t slots [QUEUE_DEPTH];
  stq_pkg::req_t  req_q;
  stq_pkg::slot_t cur;
  stq_pkg::slot_t new_slot;
  stq_pkg::rsp_t  rsp_next;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [IW-1:0] best;
  logic [IW-1:0] rm_pos;
  logic [31:0]   best_age;
  logic [31:0]   age;
  logic [7:0]    best_owner;
  logic [31:0]   best_payload;
  logic          best_notify;
  logic          found;
  logic          better;
  logic [31:0]   stamp_cnt;
  logic          fire;

  assign cur    = slots[idx[IW-1:0]];
  assign age    = stamp_cnt - cur.stamp;
  assign better = (idx < count) && (cur.owner == req_q.owner_id) &&
                  (!found || (age > best_age));
  assign rm_pos = dc.remove_best ? best : '0;

  always_comb begin
    new_slot.deadline = req_q.time_req;
    new_slot.owner    = req_q.owner_id;
    new_slot.payload  = req_q.payload;
    new_slot.notify   = req_q.has_callback;
    new_slot.stamp    = stamp_cnt;
  end

  always_comb begin
    st.cmd        = req_q.cmd;
    st.owner_zero = (req_q.owner_id == 8'd0);
    st.full       = (count >= CW'(QUEUE_DEPTH));
    st.scan_end   = (idx >= count);
    st.ins_stop   = (cur.deadline > req_q.time_req);
    st.found      = found;
    st.head_lt    = (count != '0) && (slots[0].deadline < req_q.time_req);
  end

  // slot shifting: each slot only looks at its neighbors
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (dc.insert) begin
        if (i > int'(idx)) begin
          slots[i] <= slots[(i > 0) ? i - 1 : 0];
        end else if (i == int'(idx)) begin
          slots[i] <= new_slot;
        end
      end else if (dc.remove_best || dc.pop_head) begin
        if (i >= int'(rm_pos) && i < QUEUE_DEPTH - 1) begin
          slots[i] <= slots[i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dc.latch) begin
      req_q <= req;
    end
    if (dc.step && better) begin
      best         <= idx[IW-1:0];
      best_age     <= age;
      best_owner   <= cur.owner;
      best_payload <= cur.payload;
      best_notify  <= cur.notify;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      found     <= 1'b0;
      stamp_cnt <= '0;
    end else begin
      if (dc.latch || dc.remove_best) begin
        idx   <= '0;
        found <= 1'b0;
      end else if (dc.step) begin
        idx <= idx + 1'b1;
        if (better) begin
          found <= 1'b1;
        end
      end
      if (dc.insert) begin
        count     <= count + 1'b1;
        stamp_cnt <= stamp_cnt + 32'd1;
      end else if (dc.remove_best || dc.pop_head) begin
        count <= count - 1'b1;
      end else if (dc.clear) begin
        count <= '0;
      end
    end
  end

  assign fire = (dc.remove_best && best_notify) || (dc.pop_head && slots[0].notify);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= fire || dc.emit_done;
    end
  end

  always_comb begin
    rsp_next = '0;
    if (dc.emit_done) begin
      rsp_next.kind   = stq_pkg::KIND_DONE;
      rsp_next.status = dc.status;
      rsp_next.last   = 1'b1;
    end else if (dc.remove_best) begin
      rsp_next.kind          = stq_pkg::KIND_FIRED;
      rsp_next.fired_owner   = best_owner;
      rsp_next.fired_payload = best_payload;
    end else if (dc.pop_head) begin
      rsp_next.kind          = stq_pkg::KIND_FIRED;
      rsp_next.fired_owner   = slots[0].owner;
      rsp_next.fired_time    = slots[0].deadline;
      rsp_next.fired_payload = slots[0].payload;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule
`default_nettype wire

FILE: design/stq_checker.sv
`default_nettype none
module stq_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire stq_pkg::rsp_t rsp,
  input wire logic          rsp_valid
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !rsp_valid)
    else $error("request accepted but block not busy");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == stq_pkg::KIND_DONE |-> rsp.last && !busy)
    else $error("done result malformed or block still busy");

  a_fired_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == stq_pkg::KIND_FIRED |->
      busy && !rsp.last && rsp.status == stq_pkg::STATUS_OK)
    else $error("fired report outside a request");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy && $past(!busy) |-> !rsp_valid)
    else $error("result while idle");

endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .rsp       (rsp),
  .rsp_valid (rsp_valid)
);
`default_nettype wire
